/* design/mlr_pkg.sv */
// shared types, codes and helper functions of the midpoint line rasteriser
package mlr_pkg;

    // request kind carried in tuser on the input side
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // octant codes
    typedef logic [2:0] t_octant;
    localparam t_octant OCT0 = 3'd0;
    localparam t_octant OCT1 = 3'd1;
    localparam t_octant OCT2 = 3'd2;
    localparam t_octant OCT3 = 3'd3;
    localparam t_octant OCT4 = 3'd4;
    localparam t_octant OCT5 = 3'd5;
    localparam t_octant OCT6 = 3'd6;
    localparam t_octant OCT7 = 3'd7;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // width of one queue entry for a given coordinate width
    function automatic int entry_w(input int n);
        return 6 * n + 10;
    endfunction

    // x is the major axis in octants 0, 3, 4 and 7
    function automatic logic major_is_x(input t_octant z);
        logic r;
        unique case (z) inside
            OCT0, OCT3, OCT4, OCT7: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

    // x runs in the positive direction in octants 0, 1, 6 and 7
    function automatic logic x_positive(input t_octant z);
        logic r;
        unique case (z) inside
            OCT0, OCT1, OCT6, OCT7: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

    // y runs in the positive direction in octants 0 to 3
    function automatic logic y_positive(input t_octant z);
        logic r;
        unique case (z) inside
            OCT0, OCT1, OCT2, OCT3: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* design/mlr_front.sv */
// front end: accepts requests, takes endpoint deltas and sets up each line
module mlr_front #(
    parameter  int COORD_BITS = 11,
    localparam int EW         = mlr_pkg::entry_w(COORD_BITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  mlr_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output logic [EW-1:0]       o_entry
);
    import mlr_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = N + 2;

    // delta stage registers
    logic           r_a_valid;
    logic           r_a_op;
    logic [N-1:0]   r_a_x;
    logic [N-1:0]   r_a_y;
    logic [N:0]     r_a_dx;
    logic [N:0]     r_a_ndx;
    logic [N:0]     r_a_dy;
    logic [N:0]     r_a_ndy;

    // setup signals
    logic           x_neg;
    logic           y_neg;
    logic           x_zero;
    logic           y_zero;
    logic [N-1:0]   ax;
    logic [N-1:0]   ay;
    logic [DW-1:0]  ax_e;
    logic [DW-1:0]  ay_e;
    logic [DW-1:0]  diff_xy;
    logic [DW-1:0]  diff_yx;
    logic [DW-1:0]  dec_x;
    logic [DW-1:0]  dec_y;
    logic           ge_x;
    logic           ge_y;
    t_octant        zone;
    logic           maj_x;
    logic [DW-1:0]  dec;
    logic [DW-1:0]  inc_s;
    logic [DW-1:0]  inc_d;
    logic [N-1:0]   remain;

    assign o_ready = !r_a_valid || !i_q_status.full;
    assign o_push  = r_a_valid && !i_q_status.full;

    // delta stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    // deltas in both directions, so the magnitude is only a selection later
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_op  <= i_op;
            r_a_x   <= i_x_start;
            r_a_y   <= i_y_start;
            r_a_dx  <= {i_x_end[N-1], i_x_end} - {i_x_start[N-1], i_x_start};
            r_a_ndx <= {i_x_start[N-1], i_x_start} - {i_x_end[N-1], i_x_end};
            r_a_dy  <= {i_y_end[N-1], i_y_end} - {i_y_start[N-1], i_y_start};
            r_a_ndy <= {i_y_start[N-1], i_y_start} - {i_y_end[N-1], i_y_end};
        end
    end

    // magnitudes and the candidate setup values for either major axis
    always_comb begin
        x_neg   = r_a_dx[N];
        y_neg   = r_a_dy[N];
        x_zero  = (r_a_dx == '0);
        y_zero  = (r_a_dy == '0);
        ax      = x_neg ? r_a_ndx[N-1:0] : r_a_dx[N-1:0];
        ay      = y_neg ? r_a_ndy[N-1:0] : r_a_dy[N-1:0];
        ax_e    = {2'b00, ax};
        ay_e    = {2'b00, ay};
        diff_xy = ax_e - ay_e;
        diff_yx = ay_e - ax_e;
        dec_x   = {ay_e[DW-2:0], 1'b0} - ax_e;
        dec_y   = {ax_e[DW-2:0], 1'b0} - ay_e;
        ge_x    = !diff_xy[DW-1];
        ge_y    = !diff_yx[DW-1];
    end

    // octant classification, tests in fixed order
    always_comb begin
        if (!x_neg && !y_neg) begin
            zone = ge_x ? OCT0 : OCT1;
        end else if ((x_neg || x_zero) && !y_neg) begin
            zone = ge_y ? OCT2 : OCT3;
        end else if ((x_neg || x_zero) && (y_neg || y_zero)) begin
            zone = ge_x ? OCT4 : OCT5;
        end else begin
            zone = ge_y ? OCT6 : OCT7;
        end
    end

    // decision variable and increments for the chosen major axis
    always_comb begin
        maj_x = major_is_x(zone);
        if (maj_x) begin
            dec    = dec_x;
            inc_s  = {ay_e[DW-2:0], 1'b0};
            inc_d  = {diff_yx[DW-2:0], 1'b0};
            remain = ax;
        end else begin
            dec    = dec_y;
            inc_s  = {ax_e[DW-2:0], 1'b0};
            inc_d  = {diff_xy[DW-2:0], 1'b0};
            remain = ay;
        end
    end

    assign o_entry = {remain, inc_d, inc_s, dec, zone, r_a_y, r_a_x, r_a_op};

endmodule

/* design/mlr_queue.sv */
// short first-in first-out queue between the front and back ends
module mlr_queue #(
    parameter int WIDTH = 76
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output mlr_pkg::t_q_status o_status,
    output logic [WIDTH-1:0]   o_data
);
    import mlr_pkg::*;

    logic [WIDTH-1:0]  r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_status.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* design/mlr_back.sv */
// back end: holds the line state, steps one pixel per request, registers the result
module mlr_back #(
    parameter  int COORD_BITS = 11,
    localparam int EW         = mlr_pkg::entry_w(COORD_BITS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mlr_pkg::t_q_status    i_q_status,
    input  logic [EW-1:0]         i_entry,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output mlr_pkg::t_octant      o_octant,
    output logic                  o_pixel_valid,
    output logic                  o_last_pixel
);
    import mlr_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = N + 2;

    // unpacked queue entry
    logic          q_op;
    logic [N-1:0]  q_x;
    logic [N-1:0]  q_y;
    t_octant       q_zone;
    logic [DW-1:0] q_dec;
    logic [DW-1:0] q_inc_s;
    logic [DW-1:0] q_inc_d;
    logic [N-1:0]  q_remain;

    // line state
    logic          r_active;
    logic [N-1:0]  r_cur_x;
    logic [N-1:0]  r_cur_y;
    t_octant       r_zone;
    logic [DW-1:0] r_dec;
    logic [DW-1:0] r_inc_s;
    logic [DW-1:0] r_inc_d;
    logic [N-1:0]  r_remain;
    logic          n_active;
    logic [N-1:0]  n_cur_x;
    logic [N-1:0]  n_cur_y;
    t_octant       n_zone;
    logic [DW-1:0] n_dec;
    logic [DW-1:0] n_inc_s;
    logic [DW-1:0] n_inc_d;
    logic [N-1:0]  n_remain;

    // output register
    logic          r_out_valid;
    logic [N-1:0]  r_px;
    logic [N-1:0]  r_py;
    t_octant       r_oct;
    logic          r_pv;
    logic          r_last;
    logic [N-1:0]  n_px;
    logic [N-1:0]  n_py;
    t_octant       n_oct;
    logic          n_pv;
    logic          n_last;

    // step helpers
    logic          diag;
    logic          maj_x;
    logic [N-1:0]  delta_x;
    logic [N-1:0]  delta_y;
    logic [N-1:0]  step_x;
    logic [N-1:0]  step_y;

    assign {q_remain, q_inc_d, q_inc_s, q_dec, q_zone, q_y, q_x, q_op} = i_entry;

    assign o_pop = !i_q_status.empty && (!r_out_valid || i_ready);

    // unit step on the major axis, and on the minor axis too when diagonal
    always_comb begin
        diag    = !r_dec[DW-1];
        maj_x   = major_is_x(r_zone);
        delta_x = {{(N-1){!x_positive(r_zone)}}, 1'b1};
        delta_y = {{(N-1){!y_positive(r_zone)}}, 1'b1};
        step_x  = (maj_x || diag) ? r_cur_x + delta_x : r_cur_x;
        step_y  = (!maj_x || diag) ? r_cur_y + delta_y : r_cur_y;
    end

    // next line state and result
    always_comb begin
        n_active = r_active;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_zone   = r_zone;
        n_dec    = r_dec;
        n_inc_s  = r_inc_s;
        n_inc_d  = r_inc_d;
        n_remain = r_remain;
        n_px     = '0;
        n_py     = '0;
        n_oct    = OCT0;
        n_pv     = 1'b0;
        n_last   = 1'b0;
        if (q_op == OP_START) begin
            n_cur_x  = q_x;
            n_cur_y  = q_y;
            n_zone   = q_zone;
            n_dec    = q_dec;
            n_inc_s  = q_inc_s;
            n_inc_d  = q_inc_d;
            n_remain = q_remain;
            n_active = (q_remain != '0);
            n_px     = q_x;
            n_py     = q_y;
            n_oct    = q_zone;
            n_pv     = 1'b1;
            n_last   = (q_remain == '0);
        end else if (r_active) begin
            n_cur_x  = step_x;
            n_cur_y  = step_y;
            n_dec    = r_dec + (diag ? r_inc_d : r_inc_s);
            n_remain = r_remain - 1'b1;
            n_active = (r_remain != N'(1));
            n_px     = step_x;
            n_py     = step_y;
            n_oct    = r_zone;
            n_pv     = 1'b1;
            n_last   = (r_remain == N'(1));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active    <= n_active;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line payload and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_zone   <= n_zone;
            r_dec    <= n_dec;
            r_inc_s  <= n_inc_s;
            r_inc_d  <= n_inc_d;
            r_remain <= n_remain;
            r_px     <= n_px;
            r_py     <= n_py;
            r_oct    <= n_oct;
            r_pv     <= n_pv;
            r_last   <= n_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_octant      = r_oct;
    assign o_pixel_valid = r_pv;
    assign o_last_pixel  = r_last;

endmodule

/* design/midpoint_line_rasterizer.sv */
// A request passes the delta register, the queue, the stepping logic and the output register.
// Throughput: one request per cycle while neither the queue nor the output stalls;
// each pixel step is one add and compare. A four-entry queue parts setup from stepping,
// so input keeps flowing under output stalls until the queue is full.
// Reset (i_rst_n low, synchronous) empties the queue and output and leaves no line active.
// top level of the midpoint line rasteriser
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 11
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request side
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // op
    input  logic i_s_tuser,
    // result side
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // pixel_x, pixel_y, octant from bit 0 up, zero padded
    output logic [((2 * COORD_BITS + 3 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // pixel_valid
    output logic o_m_tuser,
    // last_pixel
    output logic o_m_tlast
);
    import mlr_pkg::*;

    localparam int N     = COORD_BITS;
    localparam int OUT_W = ((2 * N + 3 + 7) / 8) * 8;
    localparam int EW    = entry_w(N);

    t_q_status     q_status;
    logic          q_push;
    logic          q_pop;
    logic [EW-1:0] q_wdata;
    logic [EW-1:0] q_rdata;
    logic [N-1:0]  pixel_x;
    logic [N-1:0]  pixel_y;
    t_octant       octant;

    // setup front end
    mlr_front #(
        .COORD_BITS (N)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_op       (i_s_tuser),
        .i_x_start  (i_s_tdata[N-1:0]),
        .i_y_start  (i_s_tdata[2*N-1:N]),
        .i_x_end    (i_s_tdata[3*N-1:2*N]),
        .i_y_end    (i_s_tdata[4*N-1:3*N]),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_entry    (q_wdata)
    );

    // decoupling queue
    mlr_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_data   (q_rdata)
    );

    // stepping back end
    mlr_back #(
        .COORD_BITS (N)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_entry       (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_octant      (octant),
        .o_pixel_valid (o_m_tuser),
        .o_last_pixel  (o_m_tlast)
    );

    // result packing
    assign o_m_tdata = {{(OUT_W - 2 * N - 3){1'b0}}, octant, pixel_y, pixel_x};

endmodule

/* design/mlr_checker.sv */
// port-level assertions for the midpoint line rasteriser, bound to the top level
module mlr_checker #(
    parameter int COORD_BITS = 11
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    input logic i_s_tuser,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [((2 * COORD_BITS + 3 + 7) / 8) * 8 - 1:0] o_m_tdata,
    input logic o_m_tuser,
    input logic o_m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // a result without a pixel carries no coordinates and no end flag
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata == '0) && !o_m_tlast)
        else $error("inactive result not cleared");

    // the end flag only comes with a real pixel
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser)
        else $error("end flag on inactive result");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    // reset leaves the request side open
    a_rst_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("not ready after reset");

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (.*);
